@@ src/depq_pkg.sv @@
package depq_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_W     = 32;
    localparam int KIND_W     = 2;
    localparam int COUNT_W    = 7;
    localparam int OCC_W      = $clog2(CAPACITY + 1);
    localparam int GROUP_SIZE = 8;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [KIND_W-1:0]        kind_t;
    typedef logic [OCC_W-1:0]         occ_t;
    typedef logic [COUNT_W-1:0]       count_t;

    localparam kind_t KIND_INSERT  = 2'd0;
    localparam kind_t KIND_DEL_MIN = 2'd1;
    localparam kind_t KIND_DEL_MAX = 2'd2;

    // operation broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic del_min;
        logic del_max;
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATHER,
        ST_FINAL,
        ST_OUT
    } state_t;

endpackage

@@ src/double_ended_priority_queue_top.sv @@
// Double-ended priority queue for up to CAPACITY signed 32-bit values, kept
// in ascending order in a chain of cells. Each request is an insert (kind 0),
// a delete of the minimum (kind 1) or a delete of the maximum (kind 2); any
// other kind leaves the queue as it is. Every request returns one result with
// the maximum, the minimum (both 0 when empty), the count, an empty flag and
// a flag for an insert refused because the queue was full. Equal values are
// kept as separate entries. The result is offered after these registered
// steps in order: the chain updates when the request is accepted, then the
// group maxima of a two-level or-tree (groups of eight) that picks the cell
// marked as top are registered, and then the final maximum and the minimum
// are loaded into the result registers. The next request is taken once the
// result has been delivered, so a new request is not taken while one is
// still in flight. No clearing pass is needed after reset: cells carry valid
// flags.
module double_ended_priority_queue_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  depq_pkg::kind_t kind,
    input  depq_pkg::data_t value,
    output logic            out_valid,
    input  logic            out_stall,
    output depq_pkg::data_t max_value,
    output depq_pkg::data_t min_value,
    output depq_pkg::count_t count,
    output logic            is_empty,
    output logic            dropped
);
    import depq_pkg::*;

    state_t   state_reg;
    state_t   state_next;
    occ_t     occ_reg;
    occ_t     occ_next;
    logic     dropped_reg;
    logic     dropped_next;
    data_t    min_reg;
    logic     accept;
    logic     full;
    logic     load_group;
    logic     load_final;
    cell_op_t op;

    data_t cell_value [CAPACITY];
    logic  cell_valid [CAPACITY];
    logic  cell_shift [CAPACITY];
    logic  top_flag   [CAPACITY];

    logic [OCC_W+COUNT_W-1:0] occ_wide;

    assign accept = in_valid && !in_stall;
    assign full   = (occ_reg == occ_t'(CAPACITY));

    // operation for the chain: only in the cycle a request is accepted,
    // and an insert into a full queue is suppressed
    always_comb
    begin
        op = '0;
        if (accept)
        begin
            case (kind)
                KIND_INSERT:  op.ins     = !full;
                KIND_DEL_MIN: op.del_min = 1'b1;
                KIND_DEL_MAX: op.del_max = 1'b1;
                default:      op         = '0;
            endcase
        end
    end

    // live-entry count and the refused-insert flag of the current request
    always_comb
    begin
        occ_next     = occ_reg;
        dropped_next = dropped_reg;
        if (accept)
        begin
            dropped_next = (kind == KIND_INSERT) && full;
            if (op.ins)
            begin
                occ_next = occ_reg + occ_t'(1);
            end
            else if ((op.del_min || op.del_max) && (occ_reg != '0))
            begin
                occ_next = occ_reg - occ_t'(1);
            end
        end
    end

    // the sorted chain: each cell sees its lower and upper neighbor
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        data_t left_value;
        logic  left_valid;
        logic  left_shift;
        data_t right_value;
        logic  right_valid;

        if (i == 0)
        begin : g_bottom
            assign left_value = '0;
            assign left_valid = 1'b1;
            assign left_shift = 1'b0;
        end
        else
        begin : g_lower
            assign left_value = cell_value[i-1];
            assign left_valid = cell_valid[i-1];
            assign left_shift = cell_shift[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_end
            assign right_value = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_upper
            assign right_value = cell_value[i+1];
            assign right_valid = cell_valid[i+1];
        end

        depq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .ins_value   (value),
            .left_value  (left_value),
            .left_valid  (left_valid),
            .left_shift  (left_shift),
            .right_value (right_value),
            .right_valid (right_valid),
            .cell_value  (cell_value[i]),
            .cell_valid  (cell_valid[i]),
            .shift       (cell_shift[i]),
            .top         (top_flag[i])
        );
    end

    // maximum lives in the highest valid cell
    depq_max_tree u_max_tree (
        .clk        (clk),
        .load_group (load_group),
        .load_final (load_final),
        .top_flag   (top_flag),
        .cell_value (cell_value),
        .max_value  (max_value)
    );

    // next-state logic of the request sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_GATHER;
                end
            end
            ST_GATHER: state_next = ST_FINAL;
            ST_FINAL:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        load_group = 1'b0;
        load_final = 1'b0;
        case (state_reg)
            ST_IDLE:   in_stall   = 1'b0;
            ST_GATHER: load_group = 1'b1;
            ST_FINAL:  load_final = 1'b1;
            ST_OUT:    out_valid  = 1'b1;
            default:   in_stall   = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            dropped_reg <= dropped_next;
        end
    end

    // minimum sits in the bottom cell; captured with the maximum
    always_ff @(posedge clk)
    begin
        if (load_final)
        begin
            min_reg <= cell_valid[0] ? cell_value[0] : '0;
        end
    end

    assign occ_wide  = {{COUNT_W{1'b0}}, occ_reg};
    assign min_value = min_reg;
    assign count     = occ_wide[COUNT_W-1:0];
    assign is_empty  = (occ_reg == '0);
    assign dropped   = dropped_reg;

endmodule

@@ src/depq_cell.sv @@
module depq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  depq_pkg::cell_op_t  op,
    input  depq_pkg::data_t     ins_value,
    input  depq_pkg::data_t     left_value,
    input  logic                left_valid,
    input  logic                left_shift,
    input  depq_pkg::data_t     right_value,
    input  logic                right_valid,
    output depq_pkg::data_t     cell_value,
    output logic                cell_valid,
    output logic                shift,
    output logic                top
);
    import depq_pkg::*;

    data_t value_reg;
    data_t value_next;
    logic  valid_reg;
    logic  valid_next;

    // new value belongs at or below this cell, or this is the first free
    // cell: the cell moves up
    assign shift = valid_reg ? (ins_value < value_reg) : left_valid;
    assign top   = valid_reg && !right_valid;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (op.ins && shift)
        begin
            if (left_shift)
            begin
                value_next = left_value;
            end
            else
            begin
                value_next = ins_value;
            end
            valid_next = 1'b1;
        end
        else if (op.del_min)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else if (op.del_max)
        begin
            valid_next = valid_reg && right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign cell_value = value_reg;
    assign cell_valid = valid_reg;

endmodule

@@ src/depq_max_tree.sv @@
module depq_max_tree (
    input  logic            clk,
    input  logic            load_group,
    input  logic            load_final,
    input  logic            top_flag [depq_pkg::CAPACITY],
    input  depq_pkg::data_t cell_value [depq_pkg::CAPACITY],
    output depq_pkg::data_t max_value
);
    import depq_pkg::*;

    data_t masked [NUM_GROUPS][GROUP_SIZE];
    data_t group_next [NUM_GROUPS];
    data_t group_reg [NUM_GROUPS];
    data_t max_next;
    data_t max_reg;

    // only one cell carries the top flag, so an or of masked values selects it
    for (genvar g = 0; g < NUM_GROUPS; g++)
    begin : g_group
        for (genvar j = 0; j < GROUP_SIZE; j++)
        begin : g_leaf
            if (g * GROUP_SIZE + j < CAPACITY)
            begin : g_used
                assign masked[g][j] = top_flag[g * GROUP_SIZE + j]
                                      ? cell_value[g * GROUP_SIZE + j] : '0;
            end
            else
            begin : g_pad
                assign masked[g][j] = '0;
            end
        end
    end

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                group_next[g] = group_next[g] | masked[g][j];
            end
        end
    end

    always_comb
    begin
        max_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            max_next = max_next | group_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_group)
        begin
            group_reg <= group_next;
        end
        if (load_final)
        begin
            max_reg <= max_next;
        end
    end

    assign max_value = max_reg;

endmodule
